[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hw/rtl/flq_pkg.sv]
// Shared types and codes of the FIFO/LIFO queue with search.
// Depends on nothing; used by the control module, the top level and the checker.
package flq_pkg;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_GET  = 2'd2,
      OP_FIND = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_FIND,
      S_DONE
   } state_type;

   localparam logic MODE_FIFO = 1'b0;
   localparam logic MODE_LIFO = 1'b1;

endpackage

[hw/rtl/flq_store.sv]
// Entry store of the queue: one write port and one registered read port.
// Depends on nothing; instantiated by the top level.
module flq_store #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32,
   parameter int AW         = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [WORD_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [WORD_WIDTH-1:0] rd_data
);

   logic [WORD_WIDTH-1:0] mem [DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/flq_ctrl.sv]
// Sequencer of the queue: head pointer, count, the slot adders, one word
// comparator, and the response register. Depends on flq_pkg.
module flq_ctrl #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32,
   parameter int AW         = 4,
   parameter int CW         = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_mode,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_opcode,
   input  logic [31:0]           req_data_word,
   input  logic [3:0]            req_position,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [31:0]           rsp_out_word,
   output logic [3:0]            rsp_found_index,
   output logic [4:0]            rsp_count,
   output logic                  mem_wr_en,
   output logic [AW-1:0]         mem_wr_addr,
   output logic [WORD_WIDTH-1:0] mem_wr_data,
   output logic                  mem_rd_en,
   output logic [AW-1:0]         mem_rd_addr,
   input  logic [WORD_WIDTH-1:0] mem_rd_data
);

   localparam int PW = (CW > 4) ? CW : 4;
   localparam int XW = (CW > 5) ? CW : 5;
   localparam int EW = (WORD_WIDTH > 32) ? WORD_WIDTH : 32;

   flq_pkg::state_type    state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic [CW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   flq_pkg::op_type       op_ff, op_in;
   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic [3:0]            pos_ff, pos_in;
   flq_pkg::status_type   res_status_ff, res_status_in;
   logic [31:0]           res_word_ff, res_word_in;
   logic [CW-1:0]         res_found_ff, res_found_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [31:0]           rsp_word_ff, rsp_word_in;
   logic [3:0]            rsp_found_ff, rsp_found_in;
   logic [4:0]            rsp_count_ff, rsp_count_in;

   logic [EW-1:0]         req_word_ext;
   logic [EW-1:0]         rd_word_ext;
   logic [CW-1:0]         cnt_m1;
   logic [CW-1:0]         lifo_get_off;
   logic [XW-1:0]         count_ext;
   logic [PW-1:0]         found_ext;
   logic                  hit;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(off);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flq_pkg::S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      op_ff         <= op_in;
      word_ff       <= word_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_word_ff   <= res_word_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_valid_in  = cmp_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      word_in       = word_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_word_in   = res_word_ff;
      res_found_in  = res_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = word_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      req_stall    = (state_ff != flq_pkg::S_IDLE);
      req_word_ext = EW'(req_data_word);
      rd_word_ext  = EW'(mem_rd_data);
      cnt_m1       = count_ff - CW'(1);
      lifo_get_off = cnt_m1 - CW'(pos_ff);
      count_ext    = XW'(count_ff);
      found_ext    = PW'(res_found_ff);
      hit          = cmp_valid_ff && (mem_rd_data == word_ff);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         flq_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in    = flq_pkg::op_type'(req_opcode);
               word_in  = req_word_ext[WORD_WIDTH-1:0];
               pos_in   = req_position;
               state_in = flq_pkg::S_EXEC;
            end
         end
         flq_pkg::S_EXEC: begin
            res_status_in = flq_pkg::ST_OK;
            res_word_in   = '0;
            res_found_in  = '0;
            state_in      = flq_pkg::S_DONE;
            case (op_ff)
               flq_pkg::OP_PUSH: begin
                  if (count_ff == CW'(DEPTH)) begin
                     res_status_in = flq_pkg::ST_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = slot_of(head_ff, count_ff);
                     count_in    = count_ff + CW'(1);
                  end
               end
               flq_pkg::OP_POP: begin
                  if (count_ff == '0) begin
                     res_status_in = flq_pkg::ST_MISS;
                  end else begin
                     mem_rd_en = 1'b1;
                     count_in  = cnt_m1;
                     state_in  = flq_pkg::S_READ;
                     if (queue_mode == flq_pkg::MODE_LIFO) begin
                        mem_rd_addr = slot_of(head_ff, cnt_m1);
                     end else begin
                        mem_rd_addr = head_ff;
                        head_in     = slot_of(head_ff, CW'(1));
                     end
                  end
               end
               flq_pkg::OP_GET: begin
                  if (PW'(pos_ff) >= PW'(count_ff)) begin
                     res_status_in = flq_pkg::ST_MISS;
                  end else begin
                     mem_rd_en = 1'b1;
                     state_in  = flq_pkg::S_READ;
                     if (queue_mode == flq_pkg::MODE_LIFO) begin
                        mem_rd_addr = slot_of(head_ff, lifo_get_off);
                     end else begin
                        mem_rd_addr = slot_of(head_ff, CW'(pos_ff));
                     end
                  end
               end
               default: begin
                  scan_in      = '0;
                  cmp_valid_in = 1'b0;
                  state_in     = flq_pkg::S_FIND;
               end
            endcase
         end
         flq_pkg::S_READ: begin
            res_word_in = rd_word_ext[31:0];
            state_in    = flq_pkg::S_DONE;
         end
         flq_pkg::S_FIND: begin
            // One entry is read per cycle; the compare works on the registered read data.
            if (hit) begin
               res_found_in = cmp_idx_ff;
               cmp_valid_in = 1'b0;
               state_in     = flq_pkg::S_DONE;
            end else if (scan_ff < count_ff) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = slot_of(head_ff, scan_ff);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff;
               scan_in      = scan_ff + CW'(1);
            end else begin
               res_status_in = flq_pkg::ST_MISS;
               cmp_valid_in  = 1'b0;
               state_in      = flq_pkg::S_DONE;
            end
         end
         flq_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_word_in   = res_word_ff;
               rsp_found_in  = found_ext[3:0];
               rsp_count_in  = count_ext[4:0];
               state_in      = flq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = flq_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_word    = rsp_word_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_count       = rsp_count_ff;

endmodule

[hw/rtl/fifo_lifo_queue_with_search_unit.sv]
// Top level of the FIFO/LIFO word queue with search: mode register, sequencer
// and entry store. Depends on flq_pkg, flq_ctrl and flq_store.
//
// The block holds up to DEPTH words and takes one request beat at a time.
// A push, or a pop or get that fails, passes through the execute and done
// states before the next acceptance; a pop or get that reads the store adds
// a read state, and a find adds a scan state, in which it scans the held
// entries through the single read port of the store, one entry per cycle,
// with the compare in the cycle after each read. The result sits in an output
// register, so a new request is taken while a result beat is still stalled;
// the result of that request then waits in the sequencer until the stalled
// beat leaves. The mode register may be written whenever the block is idle
// and acts on the entries as they stand. The store needs no clearing after
// reset; only held entries are ever read.
module fifo_lifo_queue_with_search_unit #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_queue_mode,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_data_word,
   input  logic [3:0]  req_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_word,
   output logic [3:0]  rsp_found_index,
   output logic [4:0]  rsp_count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic                  mode_ff, mode_in;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [WORD_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [WORD_WIDTH-1:0] mem_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (csr_valid && csr_ready) begin
         mode_in = csr_queue_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= flq_pkg::MODE_FIFO;
      end else begin
         mode_ff <= mode_in;
      end
   end

   flq_ctrl #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .AW         (AW),
      .CW         (CW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .queue_mode      (mode_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_data_word   (req_data_word),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_word    (rsp_out_word),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   flq_store #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .AW         (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

[hw/rtl/flq_checker.sv]
// Port-level checker of the queue and its bind to the top level.
// Depends on flq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module flq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_out_word,
   input logic [3:0]  rsp_found_index,
   input logic [4:0]  rsp_count
);

   logic        rsp_fail;
   logic [42:0] rsp_beat;

   assign rsp_fail = rsp_valid && (rsp_status != flq_pkg::ST_OK);
   assign rsp_beat = {rsp_status, rsp_out_word, rsp_found_index, rsp_count};

   // A stalled result beat stays and keeps its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beat))

   // An accepted request keeps the block busy for at least the next cycle.
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // A failed operation returns no word.
   `ASSERT_IMPLY(a_fail_no_word, clock, reset, rsp_fail, rsp_out_word == 32'd0)

   // A failed operation reports no match index.
   `ASSERT_IMPLY(a_fail_no_index, clock, reset, rsp_fail, rsp_found_index == 4'd0)

endmodule

bind fifo_lifo_queue_with_search_unit flq_checker u_flq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_out_word    (rsp_out_word),
   .rsp_found_index (rsp_found_index),
   .rsp_count       (rsp_count)
);

[sim/tb.sv]
// Self-checking testbench for the FIFO/LIFO word queue with search.
// Depends on flq_pkg and fifo_lifo_queue_with_search_unit; it keeps its own
// queue predictor and checks every result beat against it.
module tb;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 30;

   typedef struct {
      flq_pkg::status_type status;
      logic [31:0]         out_word;
      logic [3:0]          found_index;
      logic [4:0]          count;
   } queue_rsp_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic        csr_queue_mode  = 1'b0;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode      = 2'd0;
   logic [31:0] req_data_word   = 32'd0;
   logic [3:0]  req_position    = 4'd0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_out_word;
   logic [3:0]  rsp_found_index;
   logic [4:0]  rsp_count;

   logic [31:0] model_store [DEPTH];
   logic [3:0]  model_head = 4'd0;
   logic [4:0]  model_count = 5'd0;
   logic        model_mode = flq_pkg::MODE_FIFO;

   queue_rsp_type pending_rsp [$];
   queue_rsp_type oldest_rsp;
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            sender_idle_pct = 0;
   int            stall_pct = 0;

   logic [31:0] word_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                  32'h0000_0001, 32'h8000_0000, 32'h0000_FFFF, 32'hFFFF_0000};

   fifo_lifo_queue_with_search_unit #(
      .DEPTH(DEPTH),
      .WORD_WIDTH(32)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_queue_mode(csr_queue_mode),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_data_word(req_data_word),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_word(rsp_out_word),
      .rsp_found_index(rsp_found_index),
      .rsp_count(rsp_count)
   );

   always #6 clock = ~clock;

   function automatic queue_rsp_type predict_queue_op(flq_pkg::op_type op, logic [31:0] word,
                                                      logic [3:0] pos);
      queue_rsp_type r;
      logic [3:0]    slot;
      logic [4:0]    offset;
      r.status = flq_pkg::ST_OK;
      r.out_word = 32'd0;
      r.found_index = 4'd0;
      case (op)
         flq_pkg::OP_PUSH: begin
            if (model_count >= DEPTH) begin
               r.status = flq_pkg::ST_FULL;
            end else begin
               slot = model_head + model_count[3:0];
               model_store[slot] = word;
               model_count = model_count + 5'd1;
            end
         end
         flq_pkg::OP_POP: begin
            if (model_count == 5'd0) begin
               r.status = flq_pkg::ST_MISS;
            end else if (model_mode == flq_pkg::MODE_FIFO) begin
               r.out_word = model_store[model_head];
               model_head = model_head + 4'd1;
               model_count = model_count - 5'd1;
            end else begin
               offset = model_count - 5'd1;
               slot = model_head + offset[3:0];
               r.out_word = model_store[slot];
               model_count = model_count - 5'd1;
            end
         end
         flq_pkg::OP_GET: begin
            if ({1'b0, pos} >= model_count) begin
               r.status = flq_pkg::ST_MISS;
            end else begin
               if (model_mode == flq_pkg::MODE_FIFO) begin
                  offset = {1'b0, pos};
               end else begin
                  offset = model_count - 5'd1 - {1'b0, pos};
               end
               slot = model_head + offset[3:0];
               r.out_word = model_store[slot];
            end
         end
         default: begin
            r.status = flq_pkg::ST_MISS;
            for (int i = 0; i < model_count; i++) begin
               slot = model_head + 4'(i);
               if (r.status == flq_pkg::ST_MISS && model_store[slot] == word) begin
                  r.status = flq_pkg::ST_OK;
                  r.found_index = 4'(i);
               end
            end
         end
      endcase
      r.count = model_count;
      return r;
   endfunction

   task automatic report_failure(string what, queue_rsp_type e);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected status=%0d word=%h index=%0d count=%0d,",
                  what, e.status, e.out_word, e.found_index, e.count);
         $display("   got valid=%b status=%0d word=%h index=%0d count=%0d",
                  rsp_valid, rsp_status, rsp_out_word, rsp_found_index, rsp_count);
      end
   endtask

   // Request and register beats update the predictor at the edge that accepts them.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_rsp.push_back(predict_queue_op(flq_pkg::op_type'(req_opcode),
                                                req_data_word, req_position));
      end
      if (!reset && csr_valid && csr_ready) begin
         model_mode = csr_queue_mode;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            oldest_rsp = '{flq_pkg::ST_OK, 32'd0, 4'd0, 5'd0};
            report_failure("unexpected result beat", oldest_rsp);
         end else begin
            oldest_rsp = pending_rsp.pop_front();
            if (rsp_status != oldest_rsp.status || rsp_out_word != oldest_rsp.out_word ||
                rsp_found_index != oldest_rsp.found_index || rsp_count != oldest_rsp.count) begin
               report_failure("result mismatch", oldest_rsp);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_request(flq_pkg::op_type op, logic [31:0] word, logic [3:0] pos);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_data_word <= word;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_queue_mode(logic mode);
      drain_results();
      csr_valid <= 1'b1;
      csr_queue_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_queue();
      send_request(flq_pkg::OP_POP, 32'hFFFF_FFFF, 4'd0);
      send_request(flq_pkg::OP_GET, 32'd0, 4'd0);
      send_request(flq_pkg::OP_FIND, 32'd0, 4'd15);
   endtask

   task automatic test_fill_and_overflow();
      logic [31:0] word;
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0) word = 32'h0000_0000;
         else if (i == DEPTH - 1) word = 32'hFFFF_FFFF;
         else word = 32'h0101_0101 * i;
         send_request(flq_pkg::OP_PUSH, word, 4'(i));
      end
      send_request(flq_pkg::OP_PUSH, 32'h1234_5678, 4'd0);
      send_request(flq_pkg::OP_GET, 32'd0, 4'd15);
      send_request(flq_pkg::OP_GET, 32'd0, 4'd0);
      send_request(flq_pkg::OP_FIND, 32'hFFFF_FFFF, 4'd0);
      send_request(flq_pkg::OP_FIND, 32'h0000_0000, 4'd0);
      send_request(flq_pkg::OP_FIND, 32'h1234_5678, 4'd0);
   endtask

   function automatic logic [31:0] pick_word();
      if ($urandom_range(1) == 1) return word_pool[$urandom_range(7)];
      return $urandom();
   endfunction

   task automatic test_random_traffic(int idle_pct, int stall_in, logic mode, int n_items);
      int push_pct;
      int r;
      set_queue_mode(mode);
      sender_idle_pct = idle_pct;
      stall_pct = stall_in;
      for (int k = 0; k < n_items; k++) begin
         push_pct = ((k / 40) % 2 == 0) ? 70 : 30;
         r = $urandom_range(99);
         if (r < push_pct) begin
            send_request(flq_pkg::OP_PUSH, pick_word(), 4'($urandom_range(15)));
         end else begin
            case ($urandom_range(2))
               0: send_request(flq_pkg::OP_POP, $urandom(), 4'($urandom_range(15)));
               1: send_request(flq_pkg::OP_GET, $urandom(), 4'($urandom_range(15)));
               default: send_request(flq_pkg::OP_FIND, pick_word(), 4'($urandom_range(15)));
            endcase
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      set_queue_mode(flq_pkg::MODE_FIFO);
      test_empty_queue();
      test_fill_and_overflow();
      test_random_traffic(0, 0, flq_pkg::MODE_LIFO, 160);
      test_random_traffic(62, 0, flq_pkg::MODE_FIFO, 160);
      test_random_traffic(0, 62, flq_pkg::MODE_LIFO, 160);
      test_random_traffic(24, 24, flq_pkg::MODE_FIFO, 160);
      test_random_traffic(24, 24, flq_pkg::MODE_LIFO, 160);
      test_random_traffic(62, 0, flq_pkg::MODE_LIFO, 160);
      test_random_traffic(0, 62, flq_pkg::MODE_FIFO, 160);
      test_random_traffic(0, 0, flq_pkg::MODE_FIFO, 160);
      drain_results();
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
